// ===== design/smtpse_pkg.sv =====
// shared types, constants and helper functions for the smtp command session engine
// no dependencies; imported by every module of the block

package smtpse_pkg;

   localparam int MAX_LINE = 2048;
   localparam int LP_W     = $clog2(MAX_LINE);
   localparam int MAX_RES  = 5;
   localparam int RES_CW   = $clog2(MAX_RES + 1);
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int NUM_CMD  = 8;

   localparam logic [LP_W-1:0] LINE_LAST = LP_W'(MAX_LINE - 1);

   localparam logic       REQ_BYTE    = 1'b0;
   localparam logic       REQ_CONNECT = 1'b1;
   localparam logic       KIND_REPLY  = 1'b0;
   localparam logic       KIND_BODY   = 1'b1;

   localparam logic [3:0] RID_READY     = 4'd0;
   localparam logic [3:0] RID_OK        = 4'd1;
   localparam logic [3:0] RID_HELLO     = 4'd2;
   localparam logic [3:0] RID_EHLO_BASE = 4'd3;
   localparam logic [3:0] RID_BADSEQ    = 4'd8;
   localparam logic [3:0] RID_TOOMANY   = 4'd9;
   localparam logic [3:0] RID_DATA      = 4'd10;
   localparam logic [3:0] RID_BYE       = 4'd11;
   localparam logic [3:0] RID_UNKNOWN   = 4'd12;
   localparam logic [3:0] RID_QUEUED    = 4'd13;

   localparam int EHLO_LINES = 5;

   localparam logic [2:0] CMD_EHLO = 3'd0;
   localparam logic [2:0] CMD_HELO = 3'd1;
   localparam logic [2:0] CMD_MAIL = 3'd2;
   localparam logic [2:0] CMD_RCPT = 3'd3;
   localparam logic [2:0] CMD_DATA = 3'd4;
   localparam logic [2:0] CMD_RSET = 3'd5;
   localparam logic [2:0] CMD_NOOP = 3'd6;
   localparam logic [2:0] CMD_QUIT = 3'd7;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   // command words, left aligned and padded to ten characters
   localparam logic [79:0] CMD_TEXT [NUM_CMD] = '{
      "EHLO      ", "HELO      ", "MAIL FROM:", "RCPT TO:  ",
      "DATA      ", "RSET      ", "NOOP      ", "QUIT      "
   };
   localparam logic [3:0] CMD_LEN [NUM_CMD] = '{
      4'd5, 4'd5, 4'd10, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4
   };

   typedef struct packed {
      logic       kind;
      logic [3:0] reply_id;
      logic [7:0] body_byte;
   } res_type;

   typedef struct packed {
      logic [RES_CW-1:0]     count;
      res_type [MAX_RES-1:0] ent;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic bundle_type push_res(input bundle_type bnd, input logic kind,
                                           input logic [3:0] rid, input logic [7:0] bval);
      bundle_type r;
      r = bnd;
      if (r.count < RES_CW'(MAX_RES)) begin
         r.ent[r.count[$clog2(MAX_RES)-1:0]] = '{kind: kind, reply_id: rid, body_byte: bval};
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [NUM_CMD-1:0] match_update(input logic [NUM_CMD-1:0] flags,
                                                       input logic [7:0] b,
                                                       input logic [LP_W-1:0] idx);
      logic [NUM_CMD-1:0] r;
      logic [7:0]         f;
      logic [7:0]         c;
      r = flags;
      c = '0;
      f = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
      for (int k = 0; k < NUM_CMD; k++) begin
         if (idx < LP_W'(CMD_LEN[k])) begin
            c = CMD_TEXT[k][8 * (9 - int'(idx[3:0])) +: 8];
            if (f != c) r[k] = 1'b0;
         end else if (k >= 4) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic cmd_hit(input logic [NUM_CMD-1:0] flags, input logic [2:0] k,
                                    input logic [LP_W-1:0] len);
      logic r;
      if (!flags[k]) r = 1'b0;
      else if (k < 3'd4) r = (len >= LP_W'(CMD_LEN[k]));
      else r = (len == LP_W'(CMD_LEN[k]));
      return r;
   endfunction

endpackage

// ===== design/smtpse_front.sv =====
// front part: accepts bytes, tracks line and session state, classifies each byte
// into a bundle of up to five result beats; depends on smtpse_pkg

module smtpse_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic [7:0]              req_data_byte,
   input  logic [6:0]              max_recipients,
   input  smtpse_pkg::q_status_type q_stat,
   output logic                    push,
   output smtpse_pkg::bundle_type  push_data
);
   import smtpse_pkg::*;

   logic                open_ff,   open_in;
   logic                sender_ff, sender_in;
   logic                rcpt_ff,   rcpt_in;
   logic [6:0]          rcnt_ff,   rcnt_in;
   logic                dmode_ff,  dmode_in;
   logic [LP_W-1:0]     lpos_ff,   lpos_in;
   logic [NUM_CMD-1:0]  match_ff,  match_in;
   logic                hcr_ff,    hcr_in;
   logic                hdot_ff,   hdot_in;
   logic                accept;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [7:0]      b;
      logic            sv [2];
      logic [7:0]      sb [2];
      logic [LP_W-1:0] sx [2];
      logic            done;
      logic            full;
      logic [LP_W-1:0] len;
      logic [LP_W-1:0] lnext;
      bundle_type      bnd;

      open_in   = open_ff;
      sender_in = sender_ff;
      rcpt_in   = rcpt_ff;
      rcnt_in   = rcnt_ff;
      dmode_in  = dmode_ff;
      lpos_in   = lpos_ff;
      match_in  = match_ff;
      hcr_in    = hcr_ff;
      hdot_in   = hdot_ff;
      bnd       = '0;
      b         = req_data_byte;
      done      = 1'b0;
      full      = 1'b0;
      len       = '0;
      lnext     = lpos_ff + 1'b1;
      sv[0]     = 1'b0;
      sv[1]     = 1'b0;
      sb[0]     = CHAR_CR;
      sb[1]     = b;
      sx[0]     = lpos_ff - 1'b1;
      sx[1]     = lpos_ff;

      if (accept) begin
         if (req_command == REQ_CONNECT) begin
            sender_in = 1'b0;
            rcpt_in   = 1'b0;
            rcnt_in   = '0;
            dmode_in  = 1'b0;
            lpos_in   = '0;
            match_in  = '1;
            hcr_in    = 1'b0;
            hdot_in   = 1'b0;
            open_in   = 1'b1;
            bnd       = push_res(bnd, KIND_REPLY, RID_READY, 8'h00);
         end else if (open_ff) begin
            if (hcr_ff && b == CHAR_LF) begin
               done = 1'b1;
               len  = lpos_ff - 1'b1;
            end else begin
               full    = (lnext >= LINE_LAST);
               sv[0]   = hcr_ff;
               sv[1]   = (b != CHAR_CR) || full;
               hcr_in  = (b == CHAR_CR) && !full;
               lpos_in = lnext;
               done    = full;
               len     = lnext;
            end

            // at most two content bytes: a held cr, then this byte
            for (int s = 0; s < 2; s++) begin
               if (sv[s]) begin
                  if (dmode_ff) begin
                     if (hdot_in) begin
                        hdot_in = 1'b0;
                        if (!(sx[s] == LP_W'(1) && sb[s] == CHAR_DOT))
                           bnd = push_res(bnd, KIND_BODY, 4'd0, CHAR_DOT);
                        bnd = push_res(bnd, KIND_BODY, 4'd0, sb[s]);
                     end else if (sx[s] == '0 && sb[s] == CHAR_DOT) begin
                        hdot_in = 1'b1;
                     end else begin
                        bnd = push_res(bnd, KIND_BODY, 4'd0, sb[s]);
                     end
                  end else begin
                     match_in = match_update(match_in, sb[s], sx[s]);
                  end
               end
            end

            if (done) begin
               if (dmode_ff) begin
                  if (hdot_in && !full && len == LP_W'(1)) begin
                     dmode_in = 1'b0;
                     bnd = push_res(bnd, KIND_REPLY, RID_QUEUED, 8'h00);
                  end else begin
                     if (hdot_in) bnd = push_res(bnd, KIND_BODY, 4'd0, CHAR_DOT);
                     bnd = push_res(bnd, KIND_BODY, 4'd0, CHAR_CR);
                     bnd = push_res(bnd, KIND_BODY, 4'd0, CHAR_LF);
                  end
               end else if (cmd_hit(match_in, CMD_EHLO, len)) begin
                  for (int i = 0; i < EHLO_LINES; i++)
                     bnd = push_res(bnd, KIND_REPLY, RID_EHLO_BASE + 4'(i), 8'h00);
               end else if (cmd_hit(match_in, CMD_HELO, len)) begin
                  bnd = push_res(bnd, KIND_REPLY, RID_HELLO, 8'h00);
               end else if (cmd_hit(match_in, CMD_MAIL, len)) begin
                  sender_in = 1'b1;
                  rcnt_in   = '0;
                  rcpt_in   = 1'b0;
                  bnd = push_res(bnd, KIND_REPLY, RID_OK, 8'h00);
               end else if (cmd_hit(match_in, CMD_RCPT, len)) begin
                  if (!sender_ff) begin
                     bnd = push_res(bnd, KIND_REPLY, RID_BADSEQ, 8'h00);
                  end else if (rcnt_ff < max_recipients) begin
                     rcnt_in = rcnt_ff + 1'b1;
                     rcpt_in = 1'b1;
                     bnd = push_res(bnd, KIND_REPLY, RID_OK, 8'h00);
                  end else begin
                     bnd = push_res(bnd, KIND_REPLY, RID_TOOMANY, 8'h00);
                  end
               end else if (cmd_hit(match_in, CMD_DATA, len)) begin
                  if (!sender_ff || !rcpt_ff) begin
                     bnd = push_res(bnd, KIND_REPLY, RID_BADSEQ, 8'h00);
                  end else begin
                     dmode_in = 1'b1;
                     bnd = push_res(bnd, KIND_REPLY, RID_DATA, 8'h00);
                  end
               end else if (cmd_hit(match_in, CMD_RSET, len)) begin
                  sender_in = 1'b0;
                  rcpt_in   = 1'b0;
                  rcnt_in   = '0;
                  dmode_in  = 1'b0;
                  bnd = push_res(bnd, KIND_REPLY, RID_OK, 8'h00);
               end else if (cmd_hit(match_in, CMD_NOOP, len)) begin
                  bnd = push_res(bnd, KIND_REPLY, RID_OK, 8'h00);
               end else if (cmd_hit(match_in, CMD_QUIT, len)) begin
                  sender_in = 1'b0;
                  rcpt_in   = 1'b0;
                  rcnt_in   = '0;
                  dmode_in  = 1'b0;
                  open_in   = 1'b0;
                  bnd = push_res(bnd, KIND_REPLY, RID_BYE, 8'h00);
               end else begin
                  bnd = push_res(bnd, KIND_REPLY, RID_UNKNOWN, 8'h00);
               end
               lpos_in  = '0;
               match_in = '1;
               hcr_in   = 1'b0;
               hdot_in  = 1'b0;
            end
         end
      end

      push      = accept && (bnd.count != '0);
      push_data = bnd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         sender_ff <= 1'b0;
         rcpt_ff   <= 1'b0;
         rcnt_ff   <= '0;
         dmode_ff  <= 1'b0;
         lpos_ff   <= '0;
         match_ff  <= '1;
         hcr_ff    <= 1'b0;
         hdot_ff   <= 1'b0;
      end else begin
         open_ff   <= open_in;
         sender_ff <= sender_in;
         rcpt_ff   <= rcpt_in;
         rcnt_ff   <= rcnt_in;
         dmode_ff  <= dmode_in;
         lpos_ff   <= lpos_in;
         match_ff  <= match_in;
         hcr_ff    <= hcr_in;
         hdot_ff   <= hdot_in;
      end
   end

endmodule

// ===== design/smtpse_queue.sv =====
// short queue of result bundles between the front and back parts
// depends on smtpse_pkg

module smtpse_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  smtpse_pkg::bundle_type   push_data,
   input  logic                     pop,
   output smtpse_pkg::bundle_type   head,
   output smtpse_pkg::q_status_type q_stat
);
   import smtpse_pkg::*;

   bundle_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign q_stat.full  = (count_ff == (QPTR_W + 1)'(QDEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty) else $error("pop from empty queue");
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff[QPTR_W-1:0] == QPTR_W'(wr_ff - rd_ff)) else $error("queue count mismatch");
   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      !q_stat.empty |-> head.count != '0) else $error("empty bundle in queue");

endmodule

// ===== design/smtpse_back.sv =====
// back part: walks the head bundle one beat at a time into the output register
// depends on smtpse_pkg

module smtpse_back (
   input  logic                     clock,
   input  logic                     reset,
   input  smtpse_pkg::bundle_type   head,
   input  smtpse_pkg::q_status_type q_stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_result_kind,
   output logic [3:0]               rsp_reply_id,
   output logic [7:0]               rsp_body_byte,
   output logic                     rsp_last_result
);
   import smtpse_pkg::*;

   localparam int BEAT_W = $clog2(MAX_RES);

   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              valid_ff, valid_in;
   res_type           res_ff, res_in;
   logic              last_ff, last_in;
   logic              load;
   logic              last_beat;

   assign load      = !q_stat.empty && (!valid_ff || rsp_ready);
   assign last_beat = (RES_CW'(beat_ff) + 1'b1) == head.count;
   assign pop       = load && last_beat;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff && !rsp_ready;
      res_in   = res_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = head.ent[beat_ff];
         last_in  = last_beat;
         beat_in  = last_beat ? '0 : beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = res_ff.kind;
   assign rsp_reply_id    = res_ff.reply_id;
   assign rsp_body_byte   = res_ff.body_byte;
   assign rsp_last_result = last_ff;

endmodule

// ===== design/smtp_command_session_engine.sv =====
// smtp command session engine, top level
// SMTP server session engine. Each req beat carries either one received byte
// (req_command 0) or a connection-open event (req_command 1). Each rsp beat is
// either a reply id (rsp_result_kind 0) or an unstuffed message body byte
// (rsp_result_kind 1); rsp_last_result marks the final beat caused by one
// request beat. A request beat may cause zero to five rsp beats.
// csr_wr_en/csr_wr_data set the per-transaction recipient limit (reset 20).
// The first rsp beat of a request is registered in the bundle queue and then
// in the output register. Throughput: one request beat per cycle while requests
// cause at most one rsp beat each and the receiver does not stall; a request with
// several results leaves one beat at a time through the back part's output register.
// A four-entry bundle queue between the classifier and the output lets input
// continue while the receiver stalls; req_ready drops only when it fills.
// Reset closes the session: bytes are dropped until a connection beat arrives.
// The line buffer holds at most MAX_LINE-1 bytes before a line is forced to end.
// depends on smtpse_pkg, smtpse_front, smtpse_queue, smtpse_back

module smtp_command_session_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [3:0] rsp_reply_id,
   output logic [7:0] rsp_body_byte,
   output logic       rsp_last_result,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import smtpse_pkg::*;

   logic [6:0]   max_rcpt_ff, max_rcpt_in;
   logic         push;
   logic         pop;
   bundle_type   push_data;
   bundle_type   head;
   q_status_type q_stat;

   assign max_rcpt_in = csr_wr_en ? csr_wr_data : max_rcpt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rcpt_ff <= 7'd20;
      end else begin
         max_rcpt_ff <= max_rcpt_in;
      end
   end

   smtpse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_data_byte  (req_data_byte),
      .max_recipients (max_rcpt_ff),
      .q_stat         (q_stat),
      .push           (push),
      .push_data      (push_data)
   );

   smtpse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   smtpse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_reply_id    (rsp_reply_id),
      .rsp_body_byte   (rsp_body_byte),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// ===== bench/smtpse_tb_pkg.sv =====
// scoreboard for the smtp command session engine bench: session predictor and result checker
// depends on smtpse_pkg for field codes and the line length

package smtpse_tb_pkg;
   import smtpse_pkg::*;

   typedef struct {
      bit       kind;
      bit [3:0] rid;
      bit [7:0] bval;
      bit       last;
   } reply_beat_type;

   class session_scoreboard;
      reply_beat_type expected_beats[$];
      reply_beat_type fresh_beats[$];
      int          errors;
      bit [6:0]    rcpt_limit;
      bit          sess_open;
      bit          have_sender;
      bit          has_recipient;
      bit          in_body;
      bit          held_cr;
      bit          held_dot;
      bit [6:0]    recipient_total;
      int          line_pos;
      bit [7:0]    match_flags;
      string       words [8];

      function new();
         words[CMD_EHLO] = "EHLO ";
         words[CMD_HELO] = "HELO ";
         words[CMD_MAIL] = "MAIL FROM:";
         words[CMD_RCPT] = "RCPT TO:";
         words[CMD_DATA] = "DATA";
         words[CMD_RSET] = "RSET";
         words[CMD_NOOP] = "NOOP";
         words[CMD_QUIT] = "QUIT";
         errors = 0;
         rcpt_limit = 7'd20;
         sess_open = 1'b0;
         clear_txn();
         clear_line();
      endfunction

      function void clear_line();
         line_pos = 0;
         match_flags = '1;
         held_cr = 1'b0;
         held_dot = 1'b0;
      endfunction

      function void clear_txn();
         have_sender = 1'b0;
         has_recipient = 1'b0;
         recipient_total = '0;
         in_body = 1'b0;
      endfunction

      function void push_beat(bit kind, bit [3:0] rid, bit [7:0] bval);
         reply_beat_type b;
         if (fresh_beats.size() >= MAX_RES) return;
         b.kind = kind;
         b.rid = rid;
         b.bval = bval;
         b.last = 1'b0;
         fresh_beats.push_back(b);
      endfunction

      function void take_byte(bit [7:0] b, int idx);
         bit [7:0] f;
         if (in_body) begin
            if (held_dot) begin
               held_dot = 1'b0;
               // second of two leading dots is the one kept
               if (!(idx == 1 && b == CHAR_DOT)) push_beat(KIND_BODY, '0, CHAR_DOT);
               push_beat(KIND_BODY, '0, b);
            end else if (idx == 0 && b == CHAR_DOT) begin
               held_dot = 1'b1;
            end else begin
               push_beat(KIND_BODY, '0, b);
            end
            return;
         end
         f = (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
         for (int k = 0; k < 8; k++) begin
            if (idx < words[k].len()) begin
               if (f != words[k][idx]) match_flags[k] = 1'b0;
            end else if (k >= int'(CMD_DATA)) begin
               match_flags[k] = 1'b0;
            end
         end
      endfunction

      function bit line_hits(int k, int len);
         if (!match_flags[k]) return 1'b0;
         if (k < int'(CMD_DATA)) return len >= words[k].len();
         return len == words[k].len();
      endfunction

      function void run_command(int len);
         if (line_hits(CMD_EHLO, len)) begin
            for (int i = 0; i < EHLO_LINES; i++)
               push_beat(KIND_REPLY, 4'(RID_EHLO_BASE + i), '0);
         end else if (line_hits(CMD_HELO, len)) begin
            push_beat(KIND_REPLY, RID_HELLO, '0);
         end else if (line_hits(CMD_MAIL, len)) begin
            have_sender = 1'b1;
            recipient_total = '0;
            has_recipient = 1'b0;
            push_beat(KIND_REPLY, RID_OK, '0);
         end else if (line_hits(CMD_RCPT, len)) begin
            if (!have_sender) begin
               push_beat(KIND_REPLY, RID_BADSEQ, '0);
            end else if (recipient_total < rcpt_limit) begin
               recipient_total = recipient_total + 7'd1;
               has_recipient = 1'b1;
               push_beat(KIND_REPLY, RID_OK, '0);
            end else begin
               push_beat(KIND_REPLY, RID_TOOMANY, '0);
            end
         end else if (line_hits(CMD_DATA, len)) begin
            if (!have_sender || !has_recipient) begin
               push_beat(KIND_REPLY, RID_BADSEQ, '0);
            end else begin
               in_body = 1'b1;
               push_beat(KIND_REPLY, RID_DATA, '0);
            end
         end else if (line_hits(CMD_RSET, len)) begin
            clear_txn();
            push_beat(KIND_REPLY, RID_OK, '0);
         end else if (line_hits(CMD_NOOP, len)) begin
            push_beat(KIND_REPLY, RID_OK, '0);
         end else if (line_hits(CMD_QUIT, len)) begin
            push_beat(KIND_REPLY, RID_BYE, '0);
            clear_txn();
            sess_open = 1'b0;
         end else begin
            push_beat(KIND_REPLY, RID_UNKNOWN, '0);
         end
      endfunction

      function void end_line(int len, bit full);
         if (in_body) begin
            if (held_dot && !full && len == 1) begin
               in_body = 1'b0;
               push_beat(KIND_REPLY, RID_QUEUED, '0);
            end else begin
               if (held_dot) push_beat(KIND_BODY, '0, CHAR_DOT);
               push_beat(KIND_BODY, '0, CHAR_CR);
               push_beat(KIND_BODY, '0, CHAR_LF);
            end
         end else begin
            run_command(len);
         end
         clear_line();
      endfunction

      function void note_request(bit cmd, bit [7:0] b);
         fresh_beats.delete();
         if (cmd == REQ_CONNECT) begin
            clear_txn();
            clear_line();
            sess_open = 1'b1;
            push_beat(KIND_REPLY, RID_READY, '0);
         end else if (sess_open) begin
            if (held_cr && b == CHAR_LF) begin
               end_line(line_pos - 1, 1'b0);
            end else begin
               if (held_cr) begin
                  held_cr = 1'b0;
                  take_byte(CHAR_CR, line_pos - 1);
               end
               if (b == CHAR_CR) held_cr = 1'b1;
               else take_byte(b, line_pos);
               line_pos++;
               if (line_pos >= MAX_LINE - 1) begin
                  if (held_cr) begin
                     held_cr = 1'b0;
                     take_byte(CHAR_CR, line_pos - 1);
                  end
                  end_line(line_pos, 1'b1);
               end
            end
         end
         if (fresh_beats.size() > 0) fresh_beats[$].last = 1'b1;
         foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(bit kind, bit [3:0] rid, bit [7:0] bval, bit last);
         reply_beat_type e;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: kind %0d reply_id %0d body_byte %0d", kind, rid, bval);
            errors++;
            return;
         end
         e = expected_beats.pop_front();
         compare_field("result_kind", e.kind, kind);
         compare_field("reply_id", e.rid, rid);
         compare_field("body_byte", e.bval, bval);
         compare_field("last_result", e.last, last);
      endfunction
   endclass

endpackage

// ===== bench/tb_top.sv =====
// top-level bench for smtp_command_session_engine: drives byte and connect beats,
// throttles both channels and checks every result beat through the session scoreboard
// depends on smtpse_pkg, smtpse_tb_pkg and the block's rtl

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import smtpse_pkg::*;
   import smtpse_tb_pkg::*;

   localparam int QUIET_LIMIT = 3000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic [3:0] rsp_reply_id;
   logic [7:0] rsp_body_byte;
   logic       rsp_last_result;
   logic       csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = 7'd0;

   session_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_wanted = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int sent_count = 0;

   smtp_command_session_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_reply_id    (rsp_reply_id),
      .rsp_body_byte   (rsp_body_byte),
      .rsp_last_result (rsp_last_result),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_wanted && !hold_done) begin
         hold_left = 300;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_result_kind, rsp_reply_id, rsp_body_byte, rsp_last_result);
         if (req_valid && req_ready) sb.note_request(req_command, req_data_byte);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("smtp_command_session_engine verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic c, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic connect();
      send_beat(REQ_CONNECT, 8'($urandom_range(255)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(REQ_BYTE, s[i]);
   endtask

   task automatic send_crlf();
      send_beat(REQ_BYTE, CHAR_CR);
      send_beat(REQ_BYTE, CHAR_LF);
   endtask

   // any=0 keeps to printable text, any=1 draws from all byte values
   task automatic send_tail(input int n, input bit any);
      for (int i = 0; i < n; i++)
         send_beat(REQ_BYTE, any ? 8'($urandom_range(255)) : 8'($urandom_range(8'h7e, 8'h20)));
   endtask

   function automatic string mixcase(input string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if ((r[i] | 8'h20) >= 8'h61 && (r[i] | 8'h20) <= 8'h7a && $urandom_range(1))
            r[i] = r[i] ^ 8'h20;
      return r;
   endfunction

   task automatic send_cmd(input string word, input int tail, input bit any);
      send_text(mixcase(word));
      send_tail(tail, any);
      send_crlf();
   endtask

   task automatic send_body_line();
      case ($urandom_range(5))
         0: ;
         1: begin
            send_text(".");
            send_tail($urandom_range(1, 6), 1'b0);
         end
         2: begin
            send_text("..");
            send_tail($urandom_range(0, 6), 1'b0);
         end
         3: send_tail($urandom_range(1, 8), 1'b1);
         4: send_text("...");
         default: begin
            send_text(".");
            send_beat(REQ_BYTE, CHAR_CR);
            send_tail($urandom_range(1, 4), 1'b0);
         end
      endcase
      send_crlf();
   endtask

   task automatic run_transaction();
      int n;
      if ($urandom_range(1)) send_cmd("EHLO ", $urandom_range(0, 6), 1'b0);
      else send_cmd("HELO ", $urandom_range(0, 6), 1'b0);
      send_cmd("MAIL FROM:", $urandom_range(0, 8), 1'b0);
      n = $urandom_range(1, 4);
      repeat (n) send_cmd("RCPT TO:", $urandom_range(0, 8), 1'b0);
      send_cmd("DATA", 0, 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) send_body_line();
      send_text(".");
      send_crlf();
      if ($urandom_range(9) == 0) send_cmd("RSET", 0, 1'b0);
   endtask

   task automatic broken_command();
      case ($urandom_range(6))
         0: begin
            send_cmd("RSET", 0, 1'b0);
            send_cmd("RCPT TO:", 2, 1'b0);
         end
         1: begin
            send_cmd("RSET", 0, 1'b0);
            send_cmd("DATA", 0, 1'b0);
         end
         2: send_cmd("DAT", 0, 1'b0);
         3: send_cmd("RCPT TO", 3, 1'b0);
         4: send_cmd("DATA ", 0, 1'b0);
         5: begin
            send_text("NO");
            send_beat(REQ_BYTE, 8'h00);
            send_text("OP");
            send_crlf();
         end
         default: begin
            send_text("NOOP");
            send_beat(REQ_BYTE, CHAR_CR);
            send_crlf();
         end
      endcase
   endtask

   task automatic random_traffic(input int goal);
      int first;
      int pick;
      first = sent_count;
      connect();
      while (sent_count - first < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            run_transaction();
         end else if (pick < 65) begin
            send_cmd($urandom_range(1) ? "EHLO " : "HELO ", $urandom_range(6), 1'b0);
         end else if (pick < 73) begin
            send_cmd($urandom_range(1) ? "RSET" : "NOOP", 0, 1'b0);
         end else if (pick < 83) begin
            send_tail($urandom_range(1, 10), 1'b1);
            send_crlf();
         end else if (pick < 91) begin
            broken_command();
         end else if (pick < 96) begin
            send_cmd("QUIT", 0, 1'b0);
            send_tail($urandom_range(1, 4), 1'b1);
            connect();
         end else begin
            send_tail($urandom_range(1, 5), 1'b0);
            connect();
         end
      end
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_beats.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_recipient_limit(input bit [6:0] v);
      drain_pipeline();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.rcpt_limit = v;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // closed session, then the basic command set under the reset limit
      send_beat(REQ_BYTE, 8'h48);
      connect();
      send_cmd("EHLO ", 1, 1'b0);
      send_cmd("helo ", 0, 1'b0);
      send_cmd("RCPT TO:", 0, 1'b0);
      send_cmd("DATA", 0, 1'b0);
      send_cmd("Mail From:", 0, 1'b0);
      send_cmd("rcpt to:", 0, 1'b0);
      send_cmd("data", 0, 1'b0);
      send_text("..a");
      send_crlf();
      send_text(".b");
      send_crlf();
      send_crlf();
      send_beat(REQ_BYTE, 8'h00);
      send_beat(REQ_BYTE, 8'hff);
      send_crlf();
      send_text(".");
      send_crlf();
      send_cmd("NOOP", 0, 1'b0);
      send_cmd("noop ", 0, 1'b0);
      send_crlf();
      send_cmd("QUIT", 0, 1'b0);
      send_beat(REQ_BYTE, 8'h5a);

      write_recipient_limit(7'd1);
      set_idling(54, 0);
      random_traffic(20);

      write_recipient_limit(7'd3);
      set_idling(0, 54);
      connect();
      send_cmd("MAIL FROM:", 0, 1'b0);
      repeat (4) send_cmd("RCPT TO:", 0, 1'b0);
      send_cmd("RSET", 0, 1'b0);
      random_traffic(20);

      write_recipient_limit(7'd0);
      set_idling(33, 33);
      random_traffic(20);

      // long receiver hold while ehlo replies pile up
      write_recipient_limit(7'd127);
      set_idling(0, 0);
      hold_wanted <= 1'b1;
      connect();
      repeat (6) send_cmd("EHLO ", 0, 1'b0);
      random_traffic(20);

      write_recipient_limit(7'($urandom_range(2, 63)));
      set_idling(33, 33);
      random_traffic(20);

      drain_pipeline();
      repeat (12) @(posedge clock);
      if (sb.errors == 0 && sb.expected_beats.size() == 0)
         $display("smtp_command_session_engine verification clean");
      else
         $display("smtp_command_session_engine verification failed");
      $finish;
   end

endmodule
